// ===== rtl/core/neighborhood_range_edge_detector_macros.svh =====
// ----------------------------------------------------------------------------
// neighborhood range edge detector assertion macros
// property wrappers shared by the core modules
// ----------------------------------------------------------------------------
`ifndef NEIGHBORHOOD_RANGE_EDGE_DETECTOR_MACROS_SVH
`define NEIGHBORHOOD_RANGE_EDGE_DETECTOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// plain property, checked at every edge out of reset
`define NRED_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("nred assertion failed");

// same-cycle implication
`define NRED_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nred assertion failed");

// next-cycle implication
`define NRED_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nred assertion failed");

`else

`define NRED_ASSERT(label, clk, rst_n, expr)
`define NRED_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define NRED_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/nred_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nred_pkg
// types, codes and helpers shared by the edge detector core
// ----------------------------------------------------------------------------
package nred_pkg;

    localparam int SUM_W       = 10;
    localparam int CHAN_W      = 8;
    localparam int THR_W       = 10;
    localparam int CFG_W       = 13;
    localparam int ROW_W       = 12;
    localparam int HEIGHT_W    = 13;
    localparam int WIDTH_CFG_W = 12;
    localparam int WIN_SIZE    = 9;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [THR_W-1:0]    THR_RESET    = 10'd765;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = 13'd3;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = 13'd4096;
    localparam int                  WIDTH_RESET  = 640;
    localparam int                  WIDTH_MIN    = 3;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } nred_op_t;

    typedef enum logic [1:0] {
        REG_EDGE_THRESHOLD = 2'd0,
        REG_IMAGE_WIDTH    = 2'd1,
        REG_IMAGE_HEIGHT   = 2'd2
    } nred_reg_t;

    // one request from front to back
    typedef struct packed {
        logic             is_pixel;
        logic             emit;
        logic             interior;
        logic             last;
        logic [SUM_W-1:0] up;
        logic [SUM_W-1:0] mid;
        logic [SUM_W-1:0] sum;
    } nred_item_t;

    typedef struct packed {
        logic white;
        logic last;
    } nred_result_t;

    function automatic logic [SUM_W-1:0] max2(input logic [SUM_W-1:0] a,
                                              input logic [SUM_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [SUM_W-1:0] min2(input logic [SUM_W-1:0] a,
                                              input logic [SUM_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

// ===== rtl/core/neighborhood_range_edge_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighborhood_range_edge_detector
// 3x3 neighbor range edge detector on rgb sums, raster order, with flush
//
//   channel   direction  handshake            payload
//   request   in         push / full          opcode, blue, green, red
//   result    out        pop / empty          white, last_of_frame
//   config    in         cfg_write            cfg_index, cfg_data
//
// one request per cycle sustained while full is low; the request that releases
// a result passes through the line store read, request queue, window and
// max/min stage, then the result fifo
// reset clears control and the window; line stores are not cleared
// full rises when the four-entry request queue has no room, which follows
// from the result fifo filling while pop stays low
// ----------------------------------------------------------------------------
module neighborhood_range_edge_detector #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            opcode,
    input  logic [nred_pkg::CHAN_W-1:0]     blue,
    input  logic [nred_pkg::CHAN_W-1:0]     green,
    input  logic [nred_pkg::CHAN_W-1:0]     red,
    output logic                            empty,
    input  logic                            pop,
    output logic                            white,
    output logic                            last_of_frame,
    input  logic                            cfg_write,
    input  logic [1:0]                      cfg_index,
    input  logic [nred_pkg::CFG_W-1:0]      cfg_data
);

    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int WCW    = nred_pkg::WIDTH_CFG_W;
    localparam int CMPW   = (WW > WCW) ? WW : WCW;
    localparam int W_RST  = (MAX_WIDTH < nred_pkg::WIDTH_RESET) ? MAX_WIDTH
                                                                : nred_pkg::WIDTH_RESET;
    localparam int ITEM_W = $bits(nred_pkg::nred_item_t);
    localparam int RES_W  = $bits(nred_pkg::nred_result_t);

    logic [nred_pkg::THR_W-1:0]    thr_reg;
    logic [WW-1:0]                 width_reg;
    logic [nred_pkg::HEIGHT_W-1:0] height_reg;

    logic [CMPW-1:0]               width_raw;
    logic [WW-1:0]                 width_clamped;
    logic [nred_pkg::HEIGHT_W-1:0] height_clamped;
    logic                          restart;

    logic                          q_push;
    logic                          q_pop;
    logic                          q_empty;
    logic [nred_pkg::FIFO_CNT_W-1:0] q_count;
    nred_pkg::nred_item_t          f_item;
    logic [ITEM_W-1:0]             q_rdata;
    nred_pkg::nred_item_t          b_item;

    logic                          o_push;
    nred_pkg::nred_result_t        o_result;
    logic [RES_W-1:0]              o_rdata;
    nred_pkg::nred_result_t        out_result;
    logic [nred_pkg::FIFO_CNT_W-1:0] o_count;

    // size registers saturate into their legal range
    assign width_raw = CMPW'(cfg_data[WCW-1:0]);
    always_comb
    begin
        if (width_raw < CMPW'(nred_pkg::WIDTH_MIN))
        begin
            width_clamped = WW'(nred_pkg::WIDTH_MIN);
        end
        else if (width_raw > CMPW'(MAX_WIDTH))
        begin
            width_clamped = WW'(MAX_WIDTH);
        end
        else
        begin
            width_clamped = width_raw[WW-1:0];
        end
        if (cfg_data < nred_pkg::HEIGHT_MIN)
        begin
            height_clamped = nred_pkg::HEIGHT_MIN;
        end
        else if (cfg_data > nred_pkg::HEIGHT_MAX)
        begin
            height_clamped = nred_pkg::HEIGHT_MAX;
        end
        else
        begin
            height_clamped = cfg_data;
        end
    end

    assign restart = cfg_write && ((cfg_index == nred_pkg::REG_IMAGE_WIDTH)
                                || (cfg_index == nred_pkg::REG_IMAGE_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= nred_pkg::THR_RESET;
            width_reg  <= WW'(W_RST);
            height_reg <= nred_pkg::HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                nred_pkg::REG_EDGE_THRESHOLD: thr_reg    <= cfg_data[nred_pkg::THR_W-1:0];
                nred_pkg::REG_IMAGE_WIDTH:    width_reg  <= width_clamped;
                nred_pkg::REG_IMAGE_HEIGHT:   height_reg <= height_clamped;
                default:                      ;
            endcase
        end
    end

    nred_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .opcode  (opcode),
        .blue    (blue),
        .green   (green),
        .red     (red),
        .width   (width_reg),
        .height  (height_reg),
        .restart (restart),
        .q_push  (q_push),
        .q_item  (f_item),
        .q_count (q_count)
    );

    nred_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (nred_pkg::FIFO_DEPTH)
    ) u_req_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (f_item),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty),
        .count (q_count)
    );

    assign b_item = nred_pkg::nred_item_t'(q_rdata);

    nred_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_item    (b_item),
        .q_pop     (q_pop),
        .threshold (thr_reg),
        .o_count   (o_count),
        .o_push    (o_push),
        .o_result  (o_result)
    );

    nred_queue #(
        .WIDTH (RES_W),
        .DEPTH (nred_pkg::FIFO_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (o_push),
        .wdata (o_result),
        .pop   (pop),
        .rdata (o_rdata),
        .empty (empty),
        .count (o_count)
    );

    assign out_result    = nred_pkg::nred_result_t'(o_rdata);
    assign white         = out_result.white;
    assign last_of_frame = out_result.last;

endmodule

// ===== rtl/core/nred_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nred_queue
// small synchronous fifo with occupancy count
// ----------------------------------------------------------------------------
`include "neighborhood_range_edge_detector_macros.svh"

module nred_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign do_push = push && (count_reg != CNT_W'(DEPTH));
    assign do_pop  = pop && (count_reg != '0);
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // producers hold back by credit, so a push never meets a full queue
    `NRED_ASSERT_IMP(a_no_overflow, clk, rst_n, push, count_reg < CNT_W'(DEPTH))

endmodule

// ===== rtl/core/nred_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nred_front
// accepts pixels and flushes, tracks frame position and pending results,
// keeps the two line stores and hands classified requests to the queue
// ----------------------------------------------------------------------------
`include "neighborhood_range_edge_detector_macros.svh"

module nred_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 opcode,
    input  logic [nred_pkg::CHAN_W-1:0]          blue,
    input  logic [nred_pkg::CHAN_W-1:0]          green,
    input  logic [nred_pkg::CHAN_W-1:0]          red,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]       width,
    input  logic [nred_pkg::HEIGHT_W-1:0]        height,
    input  logic                                 restart,
    output logic                                 q_push,
    output nred_pkg::nred_item_t                 q_item,
    input  logic [nred_pkg::FIFO_CNT_W-1:0]      q_count
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PW = $clog2(MAX_WIDTH + 2);
    localparam int SW = nred_pkg::SUM_W;
    localparam int RW = nred_pkg::ROW_W;
    localparam int HW = nred_pkg::HEIGHT_W;
    localparam int CW = nred_pkg::FIFO_CNT_W;

    logic [AW-1:0]   col_reg,  col_next;
    logic [RW-1:0]   row_reg,  row_next;
    logic [AW-1:0]   ocol_reg, ocol_next;
    logic [RW-1:0]   orow_reg, orow_next;
    logic [PW-1:0]   pend_reg, pend_next;
    logic            s1_valid_reg;
    logic            s1_pixel_reg;
    logic            s1_emit_reg;
    logic            s1_interior_reg;
    logic            s1_last_reg;
    logic [SW-1:0]   s1_sum_reg;
    logic [AW-1:0]   s1_col_reg;
    logic [2*SW-1:0] line_mem [MAX_WIDTH];
    logic [2*SW-1:0] line_rdata_reg;

    logic            accept;
    logic            is_pixel;
    logic [SW-1:0]   sum;
    logic            old_interior;
    logic            old_last;
    logic            emit;
    logic            col_wrap;
    logic            ocol_wrap;

    assign full     = (CW'(q_count) + CW'(s1_valid_reg)) >= CW'(nred_pkg::FIFO_DEPTH);
    assign accept   = push && !full;
    assign is_pixel = (opcode == nred_pkg::OP_PIXEL);
    assign sum      = SW'(red) + SW'(green) + SW'(blue);

    // position of the oldest pixel still owed a result
    assign old_interior = (orow_reg != '0) && ((HW'(orow_reg) + HW'(2)) <= height)
                       && (ocol_reg != '0) && (((WW+1)'(ocol_reg) + (WW+1)'(2))
                                                <= (WW+1)'(width));
    assign old_last  = ((WW'(ocol_reg) + WW'(1)) == width)
                    && ((HW'(orow_reg) + HW'(1)) == height);
    assign emit      = is_pixel ? (pend_reg > PW'(width))
                                : ((pend_reg != '0) && !old_interior);
    assign col_wrap  = (WW'(col_reg) + WW'(1)) == width;
    assign ocol_wrap = (WW'(ocol_reg) + WW'(1)) == width;

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        pend_next = pend_reg;
        if (restart)
        begin
            col_next  = '0;
            row_next  = '0;
            ocol_next = '0;
            orow_next = '0;
            pend_next = '0;
        end
        else if (accept)
        begin
            if (is_pixel)
            begin
                col_next = col_wrap ? '0 : col_reg + 1'b1;
                if (col_wrap)
                begin
                    row_next = ((HW'(row_reg) + HW'(1)) == height) ? '0 : row_reg + 1'b1;
                end
                if (!emit)
                begin
                    pend_next = pend_reg + 1'b1;
                end
            end
            else if (emit)
            begin
                pend_next = pend_reg - 1'b1;
            end
            if (emit)
            begin
                ocol_next = ocol_wrap ? '0 : ocol_reg + 1'b1;
                if (ocol_wrap)
                begin
                    orow_next = ((HW'(orow_reg) + HW'(1)) == height) ? '0 : orow_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            ocol_reg     <= '0;
            orow_reg     <= '0;
            pend_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            ocol_reg     <= ocol_next;
            orow_reg     <= orow_next;
            pend_reg     <= pend_next;
            s1_valid_reg <= accept && (is_pixel || emit);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg    <= is_pixel;
            s1_emit_reg     <= emit;
            s1_interior_reg <= old_interior;
            s1_last_reg     <= old_last;
            s1_sum_reg      <= sum;
            s1_col_reg      <= col_reg;
        end
    end

    // line stores: {row r-2, row r-1} per column, read then rewritten in the next cycle
    always_ff @(posedge clk)
    begin
        if (accept && is_pixel)
        begin
            line_rdata_reg <= line_mem[col_reg];
        end
        if (s1_valid_reg && s1_pixel_reg)
        begin
            line_mem[s1_col_reg] <= {line_rdata_reg[SW-1:0], s1_sum_reg};
        end
    end

    assign q_push          = s1_valid_reg;
    assign q_item.is_pixel = s1_pixel_reg;
    assign q_item.emit     = s1_emit_reg;
    assign q_item.interior = s1_interior_reg;
    assign q_item.last     = s1_last_reg;
    assign q_item.up       = line_rdata_reg[2*SW-1:SW];
    assign q_item.mid      = line_rdata_reg[SW-1:0];
    assign q_item.sum      = s1_sum_reg;

    `NRED_ASSERT(a_pend_bound, clk, rst_n, pend_reg <= (PW'(width) + PW'(1)))
    `NRED_ASSERT_NXT(a_restart_clears, clk, rst_n, restart,
        (pend_reg == '0) && (col_reg == '0) && (row_reg == '0) && (ocol_reg == '0))

endmodule

// ===== rtl/core/nred_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nred_back
// 3x3 sum window, neighbor max/min over registered halves and threshold compare;
// pops requests only while the result fifo has room for everything in flight
// ----------------------------------------------------------------------------
`include "neighborhood_range_edge_detector_macros.svh"

module nred_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    input  nred_pkg::nred_item_t            q_item,
    output logic                            q_pop,
    input  logic [nred_pkg::THR_W-1:0]      threshold,
    input  logic [nred_pkg::FIFO_CNT_W-1:0] o_count,
    output logic                            o_push,
    output nred_pkg::nred_result_t          o_result
);

    localparam int SW = nred_pkg::SUM_W;
    localparam int CW = nred_pkg::FIFO_CNT_W + 1;

    logic [SW-1:0] win_reg [nred_pkg::WIN_SIZE];
    logic          v1_reg;
    logic          int1_reg;
    logic          last1_reg;
    logic          v2_reg;
    logic          int2_reg;
    logic          last2_reg;
    logic [SW-1:0] hi_a_reg;
    logic [SW-1:0] hi_b_reg;
    logic [SW-1:0] lo_a_reg;
    logic [SW-1:0] lo_b_reg;
    logic [SW-1:0] hi;
    logic [SW-1:0] lo;
    logic [SW-1:0] range;

    assign q_pop = !q_empty
                && ((CW'(o_count) + CW'(v1_reg) + CW'(v2_reg)) < CW'(nred_pkg::FIFO_DEPTH));

    // window: columns shift left, new column from the line stores and the pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < nred_pkg::WIN_SIZE; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (q_pop && q_item.is_pixel)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[3*r]     <= win_reg[3*r + 1];
                win_reg[3*r + 1] <= win_reg[3*r + 2];
            end
            win_reg[2] <= q_item.up;
            win_reg[5] <= q_item.mid;
            win_reg[8] <= q_item.sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= q_pop && q_item.emit;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        int1_reg  <= q_item.interior;
        last1_reg <= q_item.last;
        int2_reg  <= int1_reg;
        last2_reg <= last1_reg;
        hi_a_reg  <= nred_pkg::max2(nred_pkg::max2(win_reg[0], win_reg[1]),
                                    nred_pkg::max2(win_reg[2], win_reg[3]));
        hi_b_reg  <= nred_pkg::max2(nred_pkg::max2(win_reg[5], win_reg[6]),
                                    nred_pkg::max2(win_reg[7], win_reg[8]));
        lo_a_reg  <= nred_pkg::min2(nred_pkg::min2(win_reg[0], win_reg[1]),
                                    nred_pkg::min2(win_reg[2], win_reg[3]));
        lo_b_reg  <= nred_pkg::min2(nred_pkg::min2(win_reg[5], win_reg[6]),
                                    nred_pkg::min2(win_reg[7], win_reg[8]));
    end

    assign hi    = nred_pkg::max2(hi_a_reg, hi_b_reg);
    assign lo    = nred_pkg::min2(lo_a_reg, lo_b_reg);
    assign range = hi - lo;

    // border pixels are black whatever the window holds
    assign o_push         = v2_reg;
    assign o_result.white = int2_reg && (range > threshold);
    assign o_result.last  = last2_reg;

    `NRED_ASSERT_IMP(a_emit_reaches_fifo, clk, rst_n,
        $past(q_pop && q_item.emit, 2), o_push)

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives pixel and flush requests into the 3x3 neighbor range edge detector
// with random gaps, pops results with random stalls and long hold-offs,
// and compares every result in order against a prediction of the line
// stores, window and pending count; threshold and frame size change between
// phases, including saturated sizes, the widest size and the tallest frame
// ----------------------------------------------------------------------------
module tb;

    localparam int         MAX_W         = 2048;
    localparam int         MAX_SUM       = 765;
    localparam int         CHW           = nred_pkg::CHAN_W;
    localparam int         SW            = nred_pkg::SUM_W;
    localparam int         CLK_HALF      = 4;
    localparam int         SETTLE        = 16;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         RANDOM_PIXELS = 600;
    localparam int         WIDE_PIXELS   = 24;
    localparam int         CYCLE_LIMIT   = 1000000;
    localparam int         REPORT_MAX    = 10;
    localparam logic [1:0] REG_UNUSED    = 2'd3;

    typedef struct {
        nred_pkg::nred_op_t op;
        logic [CHW-1:0]     b;
        logic [CHW-1:0]     g;
        logic [CHW-1:0]     r;
    } request_t;

    logic                       clk;
    logic                       rst_n;
    logic                       push;
    logic                       full;
    logic                       opcode;
    logic [CHW-1:0]             blue;
    logic [CHW-1:0]             green;
    logic [CHW-1:0]             red;
    logic                       empty;
    logic                       pop;
    logic                       white;
    logic                       last_of_frame;
    logic                       cfg_write;
    logic [1:0]                 cfg_index;
    logic [nred_pkg::CFG_W-1:0] cfg_data;

    request_t               pixel_requests[$];
    nred_pkg::nred_result_t predicted_edges[$];

    // predictor state
    logic [SW-1:0] upper_sums [MAX_W];
    logic [SW-1:0] middle_sums [MAX_W];
    logic [SW-1:0] window [nred_pkg::WIN_SIZE];
    int unsigned   thr_cur;
    int unsigned   width_cur;
    int unsigned   height_cur;
    int unsigned   col_cur;
    int unsigned   row_cur;
    int unsigned   pend_cnt;

    int  mismatches  = 0;
    int  cycle_count = 0;
    int  send_gap    = 0;
    int  pop_gap     = 0;
    int  hold_left   = 0;
    bit  req_taken   = 1'b0;
    bit  res_taken   = 1'b0;
    bit  hold_start  = 1'b0;
    bit  send_steady = 1'b0;
    bit  recv_steady = 1'b0;

    neighborhood_range_edge_detector #(
        .MAX_WIDTH(MAX_W)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .blue         (blue),
        .green        (green),
        .red          (red),
        .empty        (empty),
        .pop          (pop),
        .white        (white),
        .last_of_frame(last_of_frame),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    function automatic void model_reset();
        int i;
        thr_cur    = 32'(nred_pkg::THR_RESET);
        width_cur  = nred_pkg::WIDTH_RESET;
        height_cur = 32'(nred_pkg::HEIGHT_RESET);
        col_cur    = 0;
        row_cur    = 0;
        pend_cnt   = 0;
        for (i = 0; i < MAX_W; i++)
        begin
            upper_sums[i]  = '0;
            middle_sums[i] = '0;
        end
        for (i = 0; i < nred_pkg::WIN_SIZE; i++)
        begin
            window[i] = '0;
        end
    endfunction

    function automatic int unsigned oldest_pos();
        int unsigned total;
        int unsigned n;
        total = width_cur * height_cur;
        n     = row_cur * width_cur + col_cur;
        return (n + total - (pend_cnt % total)) % total;
    endfunction

    function automatic bit is_inner(input int unsigned lin);
        int unsigned ro;
        int unsigned co;
        ro = lin / width_cur;
        co = lin % width_cur;
        return ro >= 1 && ro + 2 <= height_cur && co >= 1 && co + 2 <= width_cur;
    endfunction

    function automatic bit range_exceeds();
        int unsigned hi;
        int unsigned lo;
        int          k;
        hi = 0;
        lo = MAX_SUM;
        for (k = 0; k < nred_pkg::WIN_SIZE; k++)
        begin
            if (k != nred_pkg::WIN_SIZE / 2)
            begin
                if (32'(window[k]) > hi) hi = 32'(window[k]);
                if (32'(window[k]) < lo) lo = 32'(window[k]);
            end
        end
        return hi >= lo && hi - lo > thr_cur;
    endfunction

    function automatic void release_oldest(input bit use_window);
        nred_pkg::nred_result_t res;
        int unsigned            lin;
        lin       = oldest_pos();
        res.white = use_window && is_inner(lin) && range_exceeds();
        res.last  = (lin + 1 == width_cur * height_cur);
        pend_cnt--;
        predicted_edges.push_back(res);
    endfunction

    function automatic void predict_request(input nred_pkg::nred_op_t op,
                                            input logic [CHW-1:0] b,
                                            input logic [CHW-1:0] g,
                                            input logic [CHW-1:0] r);
        int unsigned   c;
        logic [SW-1:0] sum;
        logic [SW-1:0] up;
        logic [SW-1:0] mid;
        int            k;
        if (op == nred_pkg::OP_FLUSH)
        begin
            // premature flush and flush with nothing pending give no result
            if (pend_cnt != 0 && !is_inner(oldest_pos())) release_oldest(1'b0);
            return;
        end
        sum = SW'(b) + SW'(g) + SW'(r);
        c   = col_cur;
        if (c >= width_cur || c >= MAX_W) c = 0;
        up  = upper_sums[c];
        mid = middle_sums[c];
        for (k = 0; k < 3; k++)
        begin
            window[k * 3]     = window[k * 3 + 1];
            window[k * 3 + 1] = window[k * 3 + 2];
        end
        window[2]      = up;
        window[5]      = mid;
        window[8]      = sum;
        upper_sums[c]  = mid;
        middle_sums[c] = sum;
        col_cur = c + 1;
        if (col_cur >= width_cur)
        begin
            col_cur = 0;
            row_cur++;
            if (row_cur >= height_cur) row_cur = 0;
        end
        pend_cnt++;
        if (pend_cnt > width_cur + 1) release_oldest(1'b1);
    endfunction

    function automatic void apply_reg(input logic [1:0] idx,
                                      input logic [nred_pkg::CFG_W-1:0] data);
        int unsigned v;
        case (idx)
            nred_pkg::REG_EDGE_THRESHOLD:
            begin
                thr_cur = 32'(data[nred_pkg::THR_W-1:0]);
            end
            nred_pkg::REG_IMAGE_WIDTH:
            begin
                v = 32'(data[nred_pkg::WIDTH_CFG_W-1:0]);
                width_cur = (v < nred_pkg::WIDTH_MIN) ? nred_pkg::WIDTH_MIN
                          : (v > MAX_W) ? MAX_W : v;
                col_cur = 0;
                row_cur = 0;
                pend_cnt = 0;
            end
            nred_pkg::REG_IMAGE_HEIGHT:
            begin
                v = 32'(data[nred_pkg::HEIGHT_W-1:0]);
                height_cur = (v < 32'(nred_pkg::HEIGHT_MIN)) ? 32'(nred_pkg::HEIGHT_MIN)
                           : (v > 32'(nred_pkg::HEIGHT_MAX)) ? 32'(nred_pkg::HEIGHT_MAX)
                           : v;
                col_cur = 0;
                row_cur = 0;
                pend_cnt = 0;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CHW-1:0] pick_chan();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return '0;
        if (p == 1) return '1;
        return CHW'($urandom_range(0, 255));
    endfunction

    function automatic void add_pixel(input int b, input int g, input int r);
        request_t req;
        req.op = nred_pkg::OP_PIXEL;
        req.b  = CHW'(b);
        req.g  = CHW'(g);
        req.r  = CHW'(r);
        pixel_requests.push_back(req);
    endfunction

    function automatic void add_flush();
        request_t req;
        req.op = nred_pkg::OP_FLUSH;
        req.b  = CHW'($urandom_range(0, 255));
        req.g  = CHW'($urandom_range(0, 255));
        req.r  = CHW'($urandom_range(0, 255));
        pixel_requests.push_back(req);
    endfunction

    // pixels, optional stray flushes, then enough flushes to empty the tail
    function automatic void queue_pixels(input int unsigned count, input bit low,
                                         input bit noise);
        int unsigned i;
        int unsigned tail;
        for (i = 0; i < count; i++)
        begin
            if (noise && $urandom_range(0, 19) == 0) add_flush();
            if (low)
                add_pixel($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
            else
                add_pixel(pick_chan(), pick_chan(), pick_chan());
        end
        tail = (count < width_cur) ? count : width_cur;
        repeat (tail + 2) add_flush();
    endfunction

    task automatic wait_drained();
        while (pixel_requests.size() != 0 || predicted_edges.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[nred_pkg::CFG_W-1:0];
        apply_reg(idx, val[nred_pkg::CFG_W-1:0]);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // request driver
    always @(negedge clk)
    begin
        if (req_taken)
        begin
            req_taken = 1'b0;
            send_gap  = send_steady ? 0 : pick_gap();
        end
        if (send_gap > 0)
        begin
            send_gap--;
            push <= 1'b0;
        end
        else if (pixel_requests.size() != 0)
        begin
            push   <= 1'b1;
            opcode <= pixel_requests[0].op;
            blue   <= pixel_requests[0].b;
            green  <= pixel_requests[0].g;
            red    <= pixel_requests[0].r;
        end
        else
        begin
            push <= 1'b0;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (hold_start)
        begin
            hold_start = 1'b0;
            hold_left  = HOLD_CYCLES;
        end
        if (res_taken)
        begin
            res_taken = 1'b0;
            pop_gap   = recv_steady ? 0 : pick_gap();
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else if (pop_gap > 0)
        begin
            pop_gap--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            predict_request(nred_pkg::nred_op_t'(opcode), blue, green, red);
            void'(pixel_requests.pop_front());
            req_taken = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        nred_pkg::nred_result_t due;
        if (rst_n && pop && !empty)
        begin
            res_taken = 1'b1;
            if (predicted_edges.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("cycle %0d: result with none expected, white=%b last=%b",
                             cycle_count, white, last_of_frame);
            end
            else
            begin
                due = predicted_edges.pop_front();
                if (white !== due.white || last_of_frame !== due.last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("cycle %0d: expected white=%b last=%b, got white=%b last=%b",
                                 cycle_count, due.white, due.last, white, last_of_frame);
                end
            end
        end
    end

    initial
    begin
        int unsigned pixels_done;
        int unsigned w_val;
        int unsigned h_val;
        int unsigned count;
        int          frames;
        int          p;
        int          i;
        bit          low;
        bit          first;
        bit          big_done;

        push      = 1'b0;
        opcode    = nred_pkg::OP_PIXEL;
        blue      = '0;
        green     = '0;
        red       = '0;
        pop       = 1'b0;
        cfg_write = 1'b0;
        cfg_index = nred_pkg::REG_EDGE_THRESHOLD;
        cfg_data  = '0;
        rst_n     = 1'b0;
        model_reset();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // flush with nothing pending
        add_flush();
        wait_drained();

        // smallest frame, zero threshold, channel extremes, unknown index ignored
        write_reg(nred_pkg::REG_EDGE_THRESHOLD, 0);
        write_reg(nred_pkg::REG_IMAGE_WIDTH, 3);
        write_reg(nred_pkg::REG_IMAGE_HEIGHT, 3);
        write_reg(REG_UNUSED, 13'h1fff);
        add_pixel(0, 0, 0);
        add_pixel(255, 255, 255);
        add_pixel(255, 0, 0);
        add_pixel(0, 255, 0);
        add_pixel(0, 0, 255);
        add_pixel(255, 255, 255);
        add_pixel(0, 0, 0);
        add_pixel(128, 64, 32);
        add_pixel(1, 2, 3);
        repeat (5) add_flush();
        wait_drained();

        // full range equal to the threshold stays black
        write_reg(nred_pkg::REG_EDGE_THRESHOLD, MAX_SUM);
        for (i = 0; i < 9; i++)
        begin
            if (i % 2 == 1) add_pixel(255, 255, 255);
            else add_pixel(0, 0, 0);
        end
        repeat (4) add_flush();
        wait_drained();

        pixels_done = 0;
        first       = 1'b1;
        big_done    = 1'b0;
        while (pixels_done < RANDOM_PIXELS)
        begin
            low = 1'b0;
            p   = $urandom_range(0, 9);
            if (p == 0) write_reg(nred_pkg::REG_EDGE_THRESHOLD, 0);
            else if (p == 1) write_reg(nred_pkg::REG_EDGE_THRESHOLD, MAX_SUM);
            else if (p == 2)
                write_reg(nred_pkg::REG_EDGE_THRESHOLD, $urandom_range(MAX_SUM + 1, 1023));
            else if (p <= 4)
            begin
                low = 1'b1;
                write_reg(nred_pkg::REG_EDGE_THRESHOLD, $urandom_range(0, 9));
            end
            else write_reg(nred_pkg::REG_EDGE_THRESHOLD, $urandom_range(0, MAX_SUM));

            if (first)
            begin
                write_reg(nred_pkg::REG_IMAGE_WIDTH, 3);
                write_reg(nred_pkg::REG_IMAGE_HEIGHT, 5);
            end
            else if ($urandom_range(0, 4) != 0)
            begin
                p = $urandom_range(0, 9);
                if (p == 0) w_val = $urandom_range(0, 2);
                else if (p == 1) w_val = $urandom_range(9, 24);
                else w_val = $urandom_range(3, 8);
                w_val = w_val | ($urandom_range(0, 1) << nred_pkg::WIDTH_CFG_W);
                p = $urandom_range(0, 9);
                if (p == 0) h_val = $urandom_range(0, 2);
                else if (p == 1) h_val = $urandom_range(4097, 8191);
                else h_val = $urandom_range(3, 6);
                write_reg(nred_pkg::REG_IMAGE_WIDTH, w_val);
                write_reg(nred_pkg::REG_IMAGE_HEIGHT, h_val);
            end
            if (!first && $urandom_range(0, 9) == 0)
                write_reg(REG_UNUSED, $urandom_range(0, 8191));

            send_steady = first || ($urandom_range(0, 3) == 0);
            recv_steady = !first && ($urandom_range(0, 3) == 0);

            frames = (width_cur > 8) ? 1 : $urandom_range(1, 3);
            if (first) frames = 3;
            if (height_cur > 24) count = width_cur * $urandom_range(2, 6);
            else count = frames * width_cur * height_cur;
            // broken frame, cut short
            if (!first && $urandom_range(0, 6) == 0) count = $urandom_range(1, count);

            if (first || $urandom_range(0, 9) == 0)
            begin
                @(posedge clk);
                hold_start = 1'b1;
            end
            queue_pixels(count, low, !first);
            pixels_done += count;
            wait_drained();

            if (!big_done && pixels_done >= RANDOM_PIXELS / 2)
            begin
                big_done = 1'b1;
                send_steady = 1'b1;
                recv_steady = 1'b1;
                // widest frame, a short run along the first row
                write_reg(nred_pkg::REG_EDGE_THRESHOLD, $urandom_range(0, MAX_SUM));
                write_reg(nred_pkg::REG_IMAGE_WIDTH, 13'h0fff);
                write_reg(nred_pkg::REG_IMAGE_HEIGHT, 3);
                queue_pixels(WIDE_PIXELS, 1'b0, 1'b0);
                wait_drained();
                // tallest frame with the narrowest width
                write_reg(nred_pkg::REG_IMAGE_HEIGHT, 13'h1fff);
                write_reg(nred_pkg::REG_IMAGE_WIDTH, 0);
                queue_pixels(12, 1'b0, 1'b1);
                wait_drained();
            end
            first = 1'b0;
        end

        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/nred_pkg.sv
rtl/core/nred_queue.sv
rtl/core/nred_front.sv
rtl/core/nred_back.sv
rtl/core/neighborhood_range_edge_detector.sv
verif/tb.sv
